FILE: src/tl_pkg.sv
// Package of shared types, codes and helpers for the text token lexer.
`default_nettype none
package tl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_WORD    = 3'd4
    } t_mode;

    localparam logic [1:0] KIND_BRACE  = 2'd0;
    localparam logic [1:0] KIND_QUOTED = 2'd1;
    localparam logic [1:0] KIND_WORD   = 2'd2;

    localparam logic [1:0] CFG_BRACE_LOW  = 2'd0;
    localparam logic [1:0] CFG_BRACE_HIGH = 2'd1;
    localparam logic [1:0] CFG_CHAR_LIMIT = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [63:0] BRACE_LOW_RESET  = 64'h0000_0380_0000_0000;
    localparam logic [63:0] BRACE_HIGH_RESET = 64'h2800_0000_0000_0000;
    localparam logic [11:0] CHAR_LIMIT_RESET = 12'd2047;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic [1:0] token_kind;
        logic       token_end;
        logic       stream_end;
    } t_result;

    typedef struct packed {
        t_result [2:0] res;
        logic [1:0]    n_res;
        t_mode         mode;
        logic [11:0]   count;
    } t_step;

    function automatic t_result f_result(logic cv, logic [7:0] ch, logic [1:0] kind,
                                         logic tend, logic send);
        t_result r;
        r.char_valid = cv;
        r.out_char   = ch;
        r.token_kind = kind;
        r.token_end  = tend;
        r.stream_end = send;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/tl_step.sv
// Combinational lexer step: results and next mode for one byte.
`default_nettype none
module tl_step #(
    parameter int MAX_KEY_LEN = 2048
) (
    input  tl_pkg::t_mode i_mode,
    input  logic [11:0]   i_count,
    input  logic [7:0]    i_byte,
    input  logic [63:0]   i_brace_low,
    input  logic [63:0]   i_brace_high,
    input  logic [11:0]   i_limit,
    output tl_pkg::t_step o_step
);
    import tl_pkg::*;

    localparam logic [11:0] LIM_MAX = 12'(MAX_KEY_LEN - 1);

    typedef struct packed {
        logic        emit;
        t_result     res;
        t_mode       mode;
        logic        set_cnt;
        logic [11:0] cnt;
    } t_idle;

    function automatic t_idle f_idle(logic [7:0] b, logic brace);
        t_idle r;
        r.emit    = 1'b0;
        r.res     = '0;
        r.mode    = MODE_IDLE;
        r.set_cnt = 1'b0;
        r.cnt     = '0;
        if (b == CH_NUL) begin
            r.emit = 1'b1;
            r.res  = f_result(1'b0, 8'h00, KIND_BRACE, 1'b0, 1'b1);
        end else if (b <= CH_SPACE) begin
            r.mode = MODE_IDLE;
        end else if (b == CH_SLASH) begin
            r.mode = MODE_SLASH;
        end else if (b == CH_QUOTE) begin
            r.mode    = MODE_QUOTED;
            r.set_cnt = 1'b1;
        end else if (brace) begin
            r.emit = 1'b1;
            r.res  = f_result(1'b1, b, KIND_BRACE, 1'b1, 1'b0);
        end else begin
            r.mode    = MODE_WORD;
            r.set_cnt = 1'b1;
            r.cnt     = 12'd1;
            r.emit    = 1'b1;
            r.res     = f_result(1'b1, b, KIND_WORD, 1'b0, 1'b0);
        end
        return r;
    endfunction

    logic        brace_b;
    logic        brace_slash;
    logic [11:0] lim;
    t_idle       idl;

    always_comb begin
        if (i_byte[7]) begin
            brace_b = 1'b0;
        end else if (i_byte[6]) begin
            brace_b = i_brace_high[i_byte[5:0]];
        end else begin
            brace_b = i_brace_low[i_byte[5:0]];
        end
        brace_slash = i_brace_low[CH_SLASH[5:0]];
        if (i_limit == 12'd0) begin
            lim = 12'd1;
        end else if (i_limit > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = i_limit;
        end
        idl = f_idle(i_byte, brace_b);
    end

    always_comb begin
        t_mode       m;
        logic [11:0] c;
        logic [1:0]  k;
        t_result [2:0] res;
        logic        word_path;
        m         = i_mode;
        c         = i_count;
        k         = 2'd0;
        res       = '0;
        word_path = 1'b0;
        case (i_mode)
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    m = MODE_COMMENT;
                end else if (brace_slash) begin
                    res[k] = f_result(1'b1, CH_SLASH, KIND_BRACE, 1'b1, 1'b0);
                    k = k + 2'd1;
                    if (idl.emit) begin
                        res[k] = idl.res;
                        k = k + 2'd1;
                    end
                    m = idl.mode;
                    if (idl.set_cnt) c = idl.cnt;
                end else begin
                    m = MODE_WORD;
                    c = 12'd1;
                    res[k] = f_result(1'b1, CH_SLASH, KIND_WORD, 1'b0, 1'b0);
                    k = k + 2'd1;
                    word_path = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (i_byte == CH_NUL) begin
                    res[k] = idl.res;
                    k = k + 2'd1;
                    m = MODE_IDLE;
                end else if (i_byte == CH_NL) begin
                    m = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                if (i_byte == CH_QUOTE || i_byte == CH_NUL) begin
                    res[k] = f_result(1'b0, 8'h00, KIND_QUOTED, 1'b1, 1'b0);
                    k = k + 2'd1;
                    m = MODE_IDLE;
                    if (i_byte == CH_NUL) begin
                        res[k] = idl.res;
                        k = k + 2'd1;
                    end
                end else if (c < lim) begin
                    res[k] = f_result(1'b1, i_byte, KIND_QUOTED, 1'b0, 1'b0);
                    k = k + 2'd1;
                    c = c + 12'd1;
                end
            end
            MODE_WORD: begin
                word_path = 1'b1;
            end
            default: begin
                if (idl.emit) begin
                    res[k] = idl.res;
                    k = k + 2'd1;
                end
                m = idl.mode;
                if (idl.set_cnt) c = idl.cnt;
            end
        endcase
        if (word_path) begin
            if (i_byte <= CH_SPACE || brace_b) begin
                res[k] = f_result(1'b0, 8'h00, KIND_WORD, 1'b1, 1'b0);
                k = k + 2'd1;
                if (idl.emit) begin
                    res[k] = idl.res;
                    k = k + 2'd1;
                end
                m = idl.mode;
                if (idl.set_cnt) c = idl.cnt;
            end else if (c < lim) begin
                res[k] = f_result(1'b1, i_byte, KIND_WORD, 1'b0, 1'b0);
                k = k + 2'd1;
                c = c + 12'd1;
            end
        end
        o_step.res   = res;
        o_step.n_res = k;
        o_step.mode  = m;
        o_step.count = c;
    end

endmodule
`default_nettype wire

FILE: src/tl_result_fifo.sv
// Small result queue that takes up to three words a cycle and gives one.
`default_nettype none
module tl_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_n,
    input  tl_pkg::t_result [2:0] i_push_data,
    input  logic                 i_pop,
    output logic [2:0]           o_free,
    output logic                 o_valid,
    output tl_pkg::t_result      o_head
);
    import tl_pkg::*;

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_free  = 3'(DEPTH) - r_count;
    assign pop     = o_valid && i_pop;
    assign n_count = r_count + {1'b0, i_push_n} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < i_push_n) begin
                r_mem[r_wr_ptr + 2'(i)] <= i_push_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_n;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: src/text_token_lexer_core.sv
// Top level of the text token lexer: config registers, input stage, lexer state and queue.
// A byte accepted is held in the input stage; its result words enter the queue once it has room.
// Throughput: one byte per cycle while each byte gives at most one result word and the output is not stalled.
// A byte giving more than one result word passes them one at a time through the single output
// port; the result queue (four words) and that single port set this rate.
// Reset (synchronous, active low) restores the register defaults and the idle mode.
`default_nettype none
module text_token_lexer_core #(
    parameter int MAX_KEY_LEN = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_char_valid,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_token_kind,
    output logic        o_token_end,
    output logic        o_stream_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import tl_pkg::*;

    logic [63:0] r_brace_low;
    logic [63:0] r_brace_high;
    logic [11:0] r_limit;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_mode       r_mode;
    logic [11:0] r_count;
    t_step       step;
    t_result     head;
    logic [2:0]  free;
    logic        fire;
    logic [1:0]  push_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brace_low  <= BRACE_LOW_RESET;
            r_brace_high <= BRACE_HIGH_RESET;
            r_limit      <= CHAR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BRACE_LOW:  r_brace_low  <= i_cfg_data;
                CFG_BRACE_HIGH: r_brace_high <= i_cfg_data;
                CFG_CHAR_LIMIT: r_limit      <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    tl_step #(
        .MAX_KEY_LEN(MAX_KEY_LEN)
    ) u_step (
        .i_mode      (r_mode),
        .i_count     (r_count),
        .i_byte      (r_in_byte),
        .i_brace_low (r_brace_low),
        .i_brace_high(r_brace_high),
        .i_limit     (r_limit),
        .o_step      (step)
    );

    assign fire       = r_in_valid && ({1'b0, step.n_res} <= free);
    assign push_n     = fire ? step.n_res : 2'd0;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_count    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_mode  <= step.mode;
                r_count <= step.count;
            end
        end
    end

    tl_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_data(step.res),
        .i_pop      (i_out_ready),
        .o_free     (free),
        .o_valid    (o_out_valid),
        .o_head     (head)
    );

    assign o_char_valid = head.char_valid;
    assign o_out_char   = head.out_char;
    assign o_token_kind = head.token_kind;
    assign o_token_end  = head.token_end;
    assign o_stream_end = head.stream_end;

endmodule
`default_nettype wire

FILE: src/tl_checker.sv
// Port-level checker for the text token lexer and its bind to the top level.
`default_nettype none
module tl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_char_valid,
    input logic [7:0]  o_out_char,
    input logic [1:0]  o_token_kind,
    input logic        o_token_end,
    input logic        o_stream_end
);
    import tl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char)
            && $stable(o_char_valid) && $stable(o_token_kind)
            && $stable(o_token_end) && $stable(o_stream_end))
        else $error("Result word changed while stalled.");

    a_stream_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_end |-> !o_char_valid && !o_token_end
            && (o_token_kind == KIND_BRACE) && (o_out_char == 8'h00))
        else $error("Malformed stream end word.");

    a_brace_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_stream_end && (o_token_kind == KIND_BRACE)
            |-> o_char_valid && o_token_end)
        else $error("Brace token is not a single marked word.");

    a_marker_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid && !o_stream_end
            |-> o_token_end && (o_token_kind != KIND_BRACE))
        else $error("Characterless word is not a token end marker.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result shown straight after reset.");

endmodule

bind text_token_lexer_core tl_checker u_tl_checker (.*);
`default_nettype wire

FILE: verif/text_token_lexer_core_tb.sv
// Self-checking testbench for the text token lexer core, with a predictor and random text.
`timescale 1ns / 1ps
module text_token_lexer_core_tb;
    import tl_pkg::*;

    localparam int KEY_LEN = 2048;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        char_valid;
    logic [7:0]  out_char;
    logic [1:0]  token_kind;
    logic        token_end;
    logic        stream_end;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data = 64'd0;

    // Lexer state and register copies used for prediction.
    t_mode       lex_mode = MODE_IDLE;
    logic [11:0] tok_chars = 12'd0;
    logic [63:0] brace_lo = BRACE_LOW_RESET;
    logic [63:0] brace_hi = BRACE_HIGH_RESET;
    logic [11:0] char_limit = CHAR_LIMIT_RESET;

    logic [7:0]  text_bytes[$];
    t_result     pending_results[$];
    int          mismatches = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        send_gaps = 1'b1;
    logic        recv_stalls = 1'b1;

    text_token_lexer_core #(
        .MAX_KEY_LEN(KEY_LEN)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_byte(in_byte),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_char_valid(char_valid),
        .o_out_char(out_char),
        .o_token_kind(token_kind),
        .o_token_end(token_end),
        .o_stream_end(stream_end),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void put_result(logic cv, logic [7:0] ch, logic [1:0] kind,
                                       logic tend, logic send);
        pending_results.push_back(t_result'{cv, ch, kind, tend, send});
    endfunction

    function automatic logic brace_hit(logic [7:0] b);
        if (b < 8'd64) return brace_lo[b[5:0]];
        if (b < 8'd128) return brace_hi[b[5:0]];
        return 1'b0;
    endfunction

    function automatic logic [11:0] kept_limit();
        logic [11:0] v;
        v = char_limit;
        if (v == 12'd0) v = 12'd1;
        if (v > 12'(KEY_LEN - 1)) v = 12'(KEY_LEN - 1);
        return v;
    endfunction

    function automatic void take_char(logic [7:0] b, logic [1:0] kind);
        if (tok_chars < kept_limit()) begin
            put_result(1'b1, b, kind, 1'b0, 1'b0);
            tok_chars++;
        end
    endfunction

    function automatic void between_tokens(logic [7:0] b);
        lex_mode = MODE_IDLE;
        if (b == CH_NUL) begin
            put_result(1'b0, CH_NUL, KIND_BRACE, 1'b0, 1'b1);
            return;
        end
        if (b <= CH_SPACE) return;
        if (b == CH_SLASH) begin
            lex_mode = MODE_SLASH;
            return;
        end
        if (b == CH_QUOTE) begin
            lex_mode = MODE_QUOTED;
            tok_chars = 12'd0;
            return;
        end
        if (brace_hit(b)) begin
            put_result(1'b1, b, KIND_BRACE, 1'b1, 1'b0);
            return;
        end
        lex_mode = MODE_WORD;
        tok_chars = 12'd1;
        put_result(1'b1, b, KIND_WORD, 1'b0, 1'b0);
    endfunction

    function automatic void in_word(logic [7:0] b);
        if (b <= CH_SPACE || brace_hit(b)) begin
            put_result(1'b0, CH_NUL, KIND_WORD, 1'b1, 1'b0);
            between_tokens(b);
        end else begin
            take_char(b, KIND_WORD);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] b);
        case (lex_mode)
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    lex_mode = MODE_COMMENT;
                end else if (brace_hit(CH_SLASH)) begin
                    put_result(1'b1, CH_SLASH, KIND_BRACE, 1'b1, 1'b0);
                    between_tokens(b);
                end else begin
                    lex_mode = MODE_WORD;
                    tok_chars = 12'd1;
                    put_result(1'b1, CH_SLASH, KIND_WORD, 1'b0, 1'b0);
                    in_word(b);
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NUL) between_tokens(b);
                else if (b == CH_NL) lex_mode = MODE_IDLE;
            end
            MODE_QUOTED: begin
                if (b == CH_QUOTE) begin
                    put_result(1'b0, CH_NUL, KIND_QUOTED, 1'b1, 1'b0);
                    lex_mode = MODE_IDLE;
                end else if (b == CH_NUL) begin
                    put_result(1'b0, CH_NUL, KIND_QUOTED, 1'b1, 1'b0);
                    between_tokens(b);
                end else begin
                    take_char(b, KIND_QUOTED);
                end
            end
            MODE_WORD: in_word(b);
            default: between_tokens(b);
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : drive
        logic nv;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            nv = in_valid;
            if (in_valid && in_ready) begin
                lex_byte(in_byte);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gaps && gap_left > 0) begin
                    gap_left--;
                end else if (text_bytes.size() > 0) begin
                    in_byte <= text_bytes.pop_front();
                    nv = 1'b1;
                    if (send_gaps && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
                end
            end
            in_valid <= nv;
        end
    end

    always @(posedge clk) begin : observe
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: char_valid %0d, out_char %0d",
                           char_valid, out_char);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("char_valid", want.char_valid, char_valid);
                    check_field("out_char", want.out_char, out_char);
                    check_field("token_kind", want.token_kind, token_kind);
                    check_field("token_end", want.token_end, token_end);
                    check_field("stream_end", want.stream_end, stream_end);
                end
            end
            if (recv_stalls && stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (recv_stalls && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
            end
        end
    end

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BRACE_LOW: brace_lo = data;
            CFG_BRACE_HIGH: brace_hi = data;
            CFG_CHAR_LIMIT: char_limit = data[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(negedge clk);
        while (text_bytes.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic gen_text(int n);
        int made;
        int pick;
        int len;
        logic [7:0] c;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) < 7) c = 8'($urandom_range(97, 122));
                    else c = 8'($urandom_range(33, 255));
                    text_bytes.push_back(c);
                end
                made += len;
            end else if (pick < 55) begin
                text_bytes.push_back(CH_QUOTE);
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CH_QUOTE) c = 8'h71;
                    text_bytes.push_back(c);
                end
                if ($urandom_range(0, 9) != 0) text_bytes.push_back(CH_QUOTE);
                made += len + 2;
            end else if (pick < 70) begin
                if ($urandom_range(0, 1) == 0) send_str("{}()';");
                else text_bytes.push_back(8'($urandom_range(33, 127)));
                made += 1;
            end else if (pick < 78) begin
                send_str("//");
                len = $urandom_range(0, 10);
                for (int i = 0; i < len; i++) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CH_NL) c = 8'h2A;
                    text_bytes.push_back(c);
                end
                text_bytes.push_back(CH_NL);
                made += 2;
            end else if (pick < 84) begin
                text_bytes.push_back(CH_SLASH);
                made += 1;
            end else if (pick < 87) begin
                text_bytes.push_back(CH_NUL);
                made += 1;
            end else begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) text_bytes.push_back(8'($urandom_range(0, 255)));
                made += len;
            end
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) text_bytes.push_back(8'($urandom_range(1, 32)));
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: words, braces, strings, comments and a NUL in word, quoted, comment and slash mode.
        send_str("a");
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(8'h7F);
        send_str("{b");
        text_bytes.push_back(8'h01);
        send_str("\"q");
        text_bytes.push_back(8'h80);
        send_str("\"//\n/x /{w");
        text_bytes.push_back(CH_NUL);
        send_str("\"s");
        text_bytes.push_back(CH_NUL);
        send_str("//");
        text_bytes.push_back(CH_NUL);
        send_str("/");
        text_bytes.push_back(CH_NUL);
        drain();

        // Every byte below 128 a brace, limit of zero with upper bits set, and a write to no register.
        cfg_write(CFG_BRACE_LOW, {64{1'b1}});
        cfg_write(CFG_BRACE_HIGH, {64{1'b1}});
        cfg_write(CFG_CHAR_LIMIT, 64'hFFFF_FFFF_FFFF_F000);
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        send_str("ab/c \"xyz\"/x//k\n/\"q\"");
        text_bytes.push_back(CH_NUL);
        gen_text(40);
        drain();

        cfg_write(CFG_BRACE_LOW, 64'd0);
        cfg_write(CFG_BRACE_HIGH, 64'd0);
        cfg_write(CFG_CHAR_LIMIT, 64'd3);
        send_gaps = 1'b0;
        gen_text(40);
        drain();

        // The largest limit is clamped one below the key length.
        cfg_write(CFG_BRACE_LOW, BRACE_LOW_RESET);
        cfg_write(CFG_BRACE_HIGH, BRACE_HIGH_RESET);
        cfg_write(CFG_CHAR_LIMIT, 64'h0FFF);
        send_gaps = 1'b1;
        recv_stalls = 1'b0;
        gen_text(35);
        drain();

        cfg_write(CFG_BRACE_LOW, {$urandom, $urandom});
        cfg_write(CFG_BRACE_HIGH, {$urandom, $urandom});
        cfg_write(CFG_CHAR_LIMIT, 64'($urandom_range(1, 8)));
        recv_stalls = 1'b1;
        gen_text(45);
        drain();

        cfg_write(CFG_BRACE_LOW, BRACE_LOW_RESET);
        cfg_write(CFG_BRACE_HIGH, BRACE_HIGH_RESET);
        cfg_write(CFG_CHAR_LIMIT, CHAR_LIMIT_RESET);
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        gen_text(35);
        drain();
        repeat (10) @(negedge clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
src/tl_pkg.sv
src/tl_step.sv
src/tl_result_fifo.sv
src/text_token_lexer_core.sv
src/tl_checker.sv
verif/text_token_lexer_core_tb.sv
